/* hdl/tmh_pkg.sv */
// Shared constants, types and codes for the timeout min-heap.
`timescale 1ns / 1ps

package tmh_pkg;

  // Heap geometry
  localparam int HEAP_DEPTH   = 32;
  localparam int IDX_W        = $clog2(HEAP_DEPTH);
  localparam int CNT_W        = $clog2(HEAP_DEPTH + 1);
  localparam int CH_W         = IDX_W + 2;
  localparam int THREAD_COUNT = 32;
  localparam int THR_W        = 5;
  localparam int KEY_W        = 32;

  // Capacity register
  localparam int CAP_W = 6;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32);

  // Command codes
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_DELETE  = 2'd1;
  localparam logic [1:0] CMD_EXTRACT = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [THR_W-1:0] thread;
    logic [KEY_W-1:0] deadline;
    logic [KEY_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [THR_W-1:0] removed;
  } res_t;

endpackage

/* hdl/tmh_key_unit.sv */
// Shared key unit: relative key of a deadline and signed compare to a reference key.
`timescale 1ns / 1ps

module tmh_key_unit (
  input  logic [tmh_pkg::KEY_W-1:0] deadline_i,
  input  logic [tmh_pkg::KEY_W-1:0] now_i,
  input  logic [tmh_pkg::KEY_W-1:0] ref_key_i,
  output logic [tmh_pkg::KEY_W-1:0] key_o,
  output logic                      lt_o,
  output logic                      eq_o
);
  import tmh_pkg::*;

  // Key wraps modulo 2^32 and reads as signed
  assign key_o = deadline_i - now_i;
  assign lt_o  = $signed(key_o) < $signed(ref_key_i);
  assign eq_o  = key_o == ref_key_i;

endmodule

/* hdl/tmh_engine.sv */
// Heap sequencer: slot and deadline memories, sift up and sift down walks.
`timescale 1ns / 1ps

module tmh_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  tmh_pkg::cmd_t             cmd_i,
  input  logic [tmh_pkg::CAP_W-1:0] cap_i,
  input  logic                      out_free_i,
  output logic                      ready_o,
  output logic                      done_o,
  output tmh_pkg::res_t             res_o
);
  import tmh_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_UKEY  = 4'd1;
  localparam logic [3:0] S_UP    = 4'd2;
  localparam logic [3:0] S_UP_S  = 4'd3;
  localparam logic [3:0] S_UP_D  = 4'd4;
  localparam logic [3:0] S_RROOT = 4'd5;
  localparam logic [3:0] S_RLAST = 4'd6;
  localparam logic [3:0] S_RKEY  = 4'd7;
  localparam logic [3:0] S_DN    = 4'd8;
  localparam logic [3:0] S_DN_LS = 4'd9;
  localparam logic [3:0] S_DN_LD = 4'd10;
  localparam logic [3:0] S_DN_RS = 4'd11;
  localparam logic [3:0] S_DN_RD = 4'd12;
  localparam logic [3:0] S_DN_MV = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [1:0]       cmd_q, cmd_d;
  logic [KEY_W-1:0] dl_q, dl_d;
  logic [KEY_W-1:0] now_q, now_d;
  logic [THR_W-1:0] cur_thr_q, cur_thr_d;
  logic [KEY_W-1:0] cur_key_q, cur_key_d;
  logic [THR_W-1:0] best_thr_q, best_thr_d;
  logic [KEY_W-1:0] best_key_q, best_key_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic             moved_q, moved_d;
  logic [THR_W-1:0] cand_thr_q, cand_thr_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] par_q, par_d;
  logic [1:0]       status_q, status_d;
  logic [THR_W-1:0] removed_q, removed_d;

  // Memories
  logic [THR_W-1:0] slot_mem [HEAP_DEPTH];
  logic [KEY_W-1:0] dl_mem   [THREAD_COUNT];
  logic [THR_W-1:0] slot_rd_q;
  logic [KEY_W-1:0] dl_rd_q;
  logic [IDX_W-1:0] slot_raddr;
  logic             slot_we;
  logic [IDX_W-1:0] slot_waddr;
  logic [THR_W-1:0] slot_wdata;
  logic             dl_we;

  // Shared key unit
  logic [KEY_W-1:0] ku_dl, ku_ref, ku_key;
  logic             ku_lt, ku_eq;

  logic [CMP_W-1:0] cap_eff;
  logic             full;
  logic [CH_W-1:0]  lc, rc, n_ext;
  logic [IDX_W-1:0] par;

  tmh_key_unit u_key (
    .deadline_i (ku_dl),
    .now_i      (now_q),
    .ref_key_i  (ku_ref),
    .key_o      (ku_key),
    .lt_o       (ku_lt),
    .eq_o       (ku_eq)
  );

  assign ku_dl  = (state_q == S_UKEY) ? dl_q : dl_rd_q;
  assign ku_ref = (state_q == S_UP_D) ? cur_key_q : best_key_q;

  assign cap_eff = (CMP_W'(cap_i) > CMP_W'(HEAP_DEPTH)) ? CMP_W'(HEAP_DEPTH) : CMP_W'(cap_i);
  assign full    = CMP_W'(cnt_q) >= cap_eff;
  assign lc      = {1'b0, idx_q, 1'b1};
  assign rc      = lc + CH_W'(1);
  assign n_ext   = CH_W'(n_q);
  assign par     = IDX_W'((idx_q - IDX_W'(1)) >> 1);

  assign ready_o = state_q == S_IDLE;
  assign res_o   = '{status: status_q, removed: removed_q};

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    cmd_d      = cmd_q;
    dl_d       = dl_q;
    now_d      = now_q;
    cur_thr_d  = cur_thr_q;
    cur_key_d  = cur_key_q;
    best_thr_d = best_thr_q;
    best_key_d = best_key_q;
    best_idx_d = best_idx_q;
    moved_d    = moved_q;
    cand_thr_d = cand_thr_q;
    idx_d      = idx_q;
    par_d      = par_q;
    status_d   = status_q;
    removed_d  = removed_q;
    slot_raddr = '0;
    slot_we    = 1'b0;
    slot_waddr = idx_q;
    slot_wdata = cur_thr_q;
    dl_we      = 1'b0;
    done_o     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d     = cmd_i.command;
          dl_d      = cmd_i.deadline;
          now_d     = cmd_i.now;
          status_d  = ST_OK;
          removed_d = '0;
          case (cmd_i.command)
            CMD_INSERT: begin
              if (full) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                dl_we     = 1'b1;
                cur_thr_d = cmd_i.thread;
                idx_d     = cnt_q[IDX_W-1:0];
                cnt_d     = cnt_q + CNT_W'(1);
                state_d   = S_UKEY;
              end
            end
            CMD_DELETE, CMD_EXTRACT: begin
              if (cnt_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                cnt_d   = cnt_q - CNT_W'(1);
                n_d     = cnt_q - CNT_W'(1);
                state_d = S_RROOT;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_UKEY: begin
        cur_key_d = ku_key;
        state_d   = S_UP;
      end
      S_UP: begin
        if (idx_q == '0) begin
          slot_we = 1'b1;
          state_d = S_DONE;
        end else begin
          slot_raddr = par;
          par_d      = par;
          state_d    = S_UP_S;
        end
      end
      S_UP_S: begin
        cand_thr_d = slot_rd_q;
        state_d    = S_UP_D;
      end
      S_UP_D: begin
        slot_we = 1'b1;
        // Move the parent down only when the new key is strictly smaller
        if (!ku_lt && !ku_eq) begin
          slot_wdata = cand_thr_q;
          idx_d      = par_q;
          state_d    = S_UP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RROOT: begin
        if (cmd_q == CMD_EXTRACT) removed_d = slot_rd_q;
        slot_raddr = n_q[IDX_W-1:0];
        state_d    = S_RLAST;
      end
      S_RLAST: begin
        cur_thr_d = slot_rd_q;
        state_d   = (n_q == '0) ? S_DONE : S_RKEY;
      end
      S_RKEY: begin
        cur_key_d = ku_key;
        idx_d     = '0;
        state_d   = S_DN;
      end
      S_DN: begin
        if (lc >= n_ext) begin
          slot_we = 1'b1;
          state_d = S_DONE;
        end else begin
          slot_raddr = lc[IDX_W-1:0];
          best_key_d = cur_key_q;
          best_thr_d = cur_thr_q;
          moved_d    = 1'b0;
          state_d    = S_DN_LS;
        end
      end
      S_DN_LS: begin
        cand_thr_d = slot_rd_q;
        state_d    = S_DN_LD;
      end
      S_DN_LD: begin
        if (ku_lt) begin
          best_key_d = ku_key;
          best_thr_d = cand_thr_q;
          best_idx_d = lc[IDX_W-1:0];
          moved_d    = 1'b1;
        end
        if (rc < n_ext) begin
          slot_raddr = rc[IDX_W-1:0];
          state_d    = S_DN_RS;
        end else begin
          state_d = S_DN_MV;
        end
      end
      S_DN_RS: begin
        cand_thr_d = slot_rd_q;
        state_d    = S_DN_RD;
      end
      S_DN_RD: begin
        // Right child wins only when strictly below the best so far
        if (ku_lt) begin
          best_key_d = ku_key;
          best_thr_d = cand_thr_q;
          best_idx_d = rc[IDX_W-1:0];
          moved_d    = 1'b1;
        end
        state_d = S_DN_MV;
      end
      S_DN_MV: begin
        slot_we = 1'b1;
        if (moved_q) begin
          slot_wdata = best_thr_q;
          idx_d      = best_idx_q;
          state_d    = S_DN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    cmd_q      <= cmd_d;
    dl_q       <= dl_d;
    now_q      <= now_d;
    cur_thr_q  <= cur_thr_d;
    cur_key_q  <= cur_key_d;
    best_thr_q <= best_thr_d;
    best_key_q <= best_key_d;
    best_idx_q <= best_idx_d;
    moved_q    <= moved_d;
    cand_thr_q <= cand_thr_d;
    idx_q      <= idx_d;
    par_q      <= par_d;
    status_q   <= status_d;
    removed_q  <= removed_d;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    slot_rd_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) dl_mem[cmd_i.thread] <= cmd_i.deadline;
    dl_rd_q <= dl_mem[slot_rd_q];
  end

endmodule

/* hdl/timeout_min_heap.sv */
// Top level of the timeout min-heap: stream ports, capacity register, result register.
`timescale 1ns / 1ps
//
// Channel   | Direction | Transfer when          | Contents
// ----------+-----------+------------------------+------------------------------------------
// s_axis    | in        | tvalid & tready        | tuser: command; tdata: thread, deadline, now
// m_axis    | out       | tvalid & tready        | tdata: status, removed thread
// cfg       | in        | cfg_we_i               | capacity (6 bits)
//
// One command at a time; s_axis_tready is high only while the sequencer idles. A refused insert,
// an empty removal or an unused command goes straight to the final state. Insert computes the
// new key, then compares it with each parent in turn and climbs while the parent is larger, up
// to the root; delete and extract read the root slot and the last slot and stop there when the
// heap empties, else they compare the left child and, where it exists, the right child on each
// level down. The next command can transfer from the cycle in which tvalid rises. The walks are
// bounded by the single slot-memory read port and the shared key unit, one compare per step.
// Reset empties the heap and sets capacity to 32; memory contents are not cleared.
// A finished result waits in the output register; a stalled m_axis holds the sequencer in its
// final state, so s_axis_tready stays low until the result register frees.

module timeout_min_heap (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // [4:0] thread_index, [36:5] deadline, [68:37] now
  input  logic [1:0]  s_axis_tuser,  // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [1:0] status, [6:2] removed_thread
  input  logic        cfg_we_i,
  input  logic [tmh_pkg::CAP_W-1:0] cfg_wdata_i
);
  import tmh_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic             out_valid_q, out_valid_d;
  res_t             out_res_q, out_res_d;
  logic             eng_ready, eng_done, out_free, accept;
  res_t             eng_res;
  cmd_t             cmd;

  assign cmd = '{command:  s_axis_tuser,
                 thread:   s_axis_tdata[4:0],
                 deadline: s_axis_tdata[36:5],
                 now:      s_axis_tdata[68:37]};

  // Accept a new command whenever the sequencer is idle
  assign s_axis_tready = eng_ready;
  assign accept        = s_axis_tvalid && eng_ready;

  // Result register frees up in the same cycle it transfers
  assign out_free = !out_valid_q || m_axis_tready;

  tmh_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .cmd_i      (cmd),
    .cap_i      (cap_q),
    .out_free_i (out_free),
    .ready_o    (eng_ready),
    .done_o     (eng_done),
    .res_o      (eng_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (eng_done) begin
      out_valid_d = 1'b1;
      out_res_d   = eng_res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cap_q       <= CAP_RESET;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_res_q.removed, out_res_q.status};

endmodule
